// ===== hw/rtl/latency_tagged_reorder_buffer_core_defines.svh =====
// Assertion macros for the reorder buffer core.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef LATENCY_TAGGED_REORDER_BUFFER_CORE_DEFINES_SVH
`define LATENCY_TAGGED_REORDER_BUFFER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LTROB_ASSERT_SAME(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ltrob assertion failed");
`define LTROB_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ltrob assertion failed");
`else
`define LTROB_ASSERT_SAME(lbl, cond, expr)
`define LTROB_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

// ===== hw/rtl/ltrob_pkg.sv =====
`timescale 1ns / 1ps
package ltrob_pkg;

    localparam int DEPTH        = 16;
    localparam int ID_BITS      = 8;
    localparam int CH_BITS      = 4;
    localparam int DELAY_BITS   = 10;
    localparam int PAYLOAD_BITS = 32;
    localparam int CAP_W        = 5;
    localparam int OCC_W        = 5;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [2:0] {
        FN_PUSH       = 3'd0,
        FN_POP_HEAD   = 3'd1,
        FN_POP_ID     = 3'd2,
        FN_POP_ID_CH  = 3'd3,
        FN_TICK       = 3'd4,
        FN_FIND_ID    = 3'd5,
        FN_FIND_ID_CH = 3'd6,
        FN_CLEAR      = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_NO_MATCH  = 3'd4
    } status_t;

    typedef struct packed {
        func_t                   func;
        logic [ID_BITS-1:0]      txn_id;
        logic [CH_BITS-1:0]      mem_channel;
        logic [DELAY_BITS-1:0]   delay_ticks;
        logic [PAYLOAD_BITS-1:0] payload_in;
    } cmd_t;

    typedef struct packed {
        status_t                 status;
        logic [PAYLOAD_BITS-1:0] payload_out;
        logic [ID_BITS-1:0]      found_id;
        logic [CH_BITS-1:0]      found_channel;
        logic [OCC_W-1:0]        occupancy;
        logic                    is_empty;
        logic                    is_full;
    } result_t;

    typedef struct packed {
        logic [ID_BITS-1:0]      id;
        logic [CH_BITS-1:0]      ch;
        logic [DELAY_BITS-1:0]   delay;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic               match_en;
        logic               use_ch;
        logic               remove;
        logic               tick;
        logic [ID_BITS-1:0] key_id;
        logic [CH_BITS-1:0] key_ch;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/ltrob_cell.sv =====
`timescale 1ns / 1ps
module ltrob_cell (
    input  logic                   clk,
    input  ltrob_pkg::cell_ctrl_t  ctrl,
    input  logic                   in_use,
    input  logic                   load,
    input  ltrob_pkg::entry_t      load_entry,
    input  ltrob_pkg::entry_t      next_entry,
    input  logic                   hit_in,
    output ltrob_pkg::entry_t      entry,
    output logic                   hit_out,
    output logic                   hit_here
);

    ltrob_pkg::entry_t entry_reg;
    ltrob_pkg::entry_t entry_next;
    logic              match;

    assign match = ctrl.match_en && in_use && (entry_reg.id == ctrl.key_id)
                   && (!ctrl.use_ch || (entry_reg.ch == ctrl.key_ch));
    assign hit_out  = hit_in || match;
    assign hit_here = match && !hit_in;
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (load)
        begin
            entry_next = load_entry;
        end
        else if (ctrl.remove && hit_out)
        begin
            // close the gap: take the younger neighbor's entry
            entry_next = next_entry;
        end
        else if (ctrl.tick && (entry_reg.delay != '0))
        begin
            entry_next.delay = entry_reg.delay - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/latency_tagged_reorder_buffer_core.sv =====
`timescale 1ns / 1ps
// The result is strobed on done in the cycle after start is taken.
// Throughput: one transaction per cycle; every cell matches and shifts in parallel.
// busy stays low; the result receiver cannot stall, so nothing holds the block off.
// Reset (rst_n low, asynchronous): occupancy 0, capacity limit 16, done low.
// Entry contents are not reset; only slots below the occupancy are ever read.
`include "latency_tagged_reorder_buffer_core_defines.svh"
module latency_tagged_reorder_buffer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  ltrob_pkg::cmd_t                    cmd,
    output logic                               done,
    output ltrob_pkg::result_t                 result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ltrob_pkg::CAP_W-1:0]        cfg_data
);

    logic [ltrob_pkg::CAP_W-1:0] cap_reg;
    logic [ltrob_pkg::CNT_W-1:0] fill_reg;
    logic [ltrob_pkg::CNT_W-1:0] fill_next;
    logic                        done_reg;
    ltrob_pkg::result_t          res_reg;
    ltrob_pkg::result_t          res_next;

    logic                        accept;
    logic [ltrob_pkg::CNT_W-1:0] lim;
    ltrob_pkg::cell_ctrl_t       ctrl;
    logic                        remove_en;
    ltrob_pkg::entry_t           load_entry;
    ltrob_pkg::entry_t           entries [ltrob_pkg::DEPTH];
    ltrob_pkg::entry_t           sel_entry;
    logic [ltrob_pkg::DEPTH:0]   hit_chain;
    logic [ltrob_pkg::DEPTH-1:0] hit_here;
    logic [ltrob_pkg::DEPTH-1:0] load;
    logic [ltrob_pkg::DEPTH-1:0] in_use;
    logic                        push_ok;
    logic                        found;
    logic                        is_empty_now;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = res_reg;

    always_comb
    begin
        if (int'(cap_reg) > ltrob_pkg::DEPTH)
        begin
            lim = ltrob_pkg::CNT_W'(ltrob_pkg::DEPTH);
        end
        else
        begin
            lim = ltrob_pkg::CNT_W'(cap_reg);
        end
    end

    assign is_empty_now = (fill_reg == '0);
    assign push_ok      = accept && (cmd.func == ltrob_pkg::FN_PUSH) && (fill_reg < lim);

    assign load_entry.id      = cmd.txn_id;
    assign load_entry.ch      = cmd.mem_channel;
    assign load_entry.delay   = cmd.delay_ticks;
    assign load_entry.payload = cmd.payload_in;

    assign ctrl.key_id   = cmd.txn_id;
    assign ctrl.key_ch   = cmd.mem_channel;
    assign ctrl.use_ch   = (cmd.func == ltrob_pkg::FN_POP_ID_CH)
                           || (cmd.func == ltrob_pkg::FN_FIND_ID_CH);
    assign ctrl.match_en = (cmd.func == ltrob_pkg::FN_POP_ID)
                           || (cmd.func == ltrob_pkg::FN_POP_ID_CH)
                           || (cmd.func == ltrob_pkg::FN_FIND_ID)
                           || (cmd.func == ltrob_pkg::FN_FIND_ID_CH);
    assign ctrl.tick     = accept && (cmd.func == ltrob_pkg::FN_TICK);
    assign ctrl.remove   = remove_en;

    // head pop forces the whole row to shift from slot 0 upward
    assign hit_chain[0] = (cmd.func == ltrob_pkg::FN_POP_HEAD);
    assign found        = hit_chain[ltrob_pkg::DEPTH];

    always_comb
    begin
        remove_en = 1'b0;
        if (accept && !is_empty_now)
        begin
            case (cmd.func)
                ltrob_pkg::FN_POP_HEAD:
                begin
                    remove_en = (entries[0].delay == '0);
                end
                ltrob_pkg::FN_POP_ID, ltrob_pkg::FN_POP_ID_CH:
                begin
                    remove_en = found;
                end
                default:
                begin
                    remove_en = 1'b0;
                end
            endcase
        end
    end

    for (genvar i = 0; i < ltrob_pkg::DEPTH; i++)
    begin : g_cell
        ltrob_pkg::entry_t next_entry;

        assign in_use[i] = (ltrob_pkg::CNT_W'(i) < fill_reg);
        assign load[i]   = push_ok && (fill_reg == ltrob_pkg::CNT_W'(i));

        if (i == ltrob_pkg::DEPTH - 1)
        begin : g_last
            assign next_entry = entries[i];
        end
        else
        begin : g_mid
            assign next_entry = entries[i+1];
        end

        ltrob_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .in_use     (in_use[i]),
            .load       (load[i]),
            .load_entry (load_entry),
            .next_entry (next_entry),
            .hit_in     (hit_chain[i]),
            .entry      (entries[i]),
            .hit_out    (hit_chain[i+1]),
            .hit_here   (hit_here[i])
        );
    end

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < ltrob_pkg::DEPTH; i++)
        begin
            sel_entry = sel_entry | ({$bits(ltrob_pkg::entry_t){hit_here[i]}} & entries[i]);
        end
    end

    always_comb
    begin
        res_next               = '0;
        res_next.status        = ltrob_pkg::ST_OK;
        fill_next              = fill_reg;
        case (cmd.func)
            ltrob_pkg::FN_PUSH:
            begin
                if (fill_reg >= lim)
                begin
                    res_next.status = ltrob_pkg::ST_FULL;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            ltrob_pkg::FN_POP_HEAD:
            begin
                if (is_empty_now)
                begin
                    res_next.status = ltrob_pkg::ST_EMPTY;
                end
                else if (entries[0].delay != '0)
                begin
                    res_next.status = ltrob_pkg::ST_NOT_READY;
                end
                else
                begin
                    res_next.payload_out   = entries[0].payload;
                    res_next.found_id      = entries[0].id;
                    res_next.found_channel = entries[0].ch;
                    fill_next              = fill_reg - 1'b1;
                end
            end
            ltrob_pkg::FN_POP_ID, ltrob_pkg::FN_POP_ID_CH:
            begin
                if (is_empty_now)
                begin
                    res_next.status = ltrob_pkg::ST_EMPTY;
                end
                else if (!found)
                begin
                    res_next.status = ltrob_pkg::ST_NO_MATCH;
                end
                else
                begin
                    res_next.payload_out   = sel_entry.payload;
                    res_next.found_id      = sel_entry.id;
                    res_next.found_channel = sel_entry.ch;
                    fill_next              = fill_reg - 1'b1;
                end
            end
            ltrob_pkg::FN_FIND_ID, ltrob_pkg::FN_FIND_ID_CH:
            begin
                if (!found)
                begin
                    res_next.status = ltrob_pkg::ST_NO_MATCH;
                end
                else
                begin
                    res_next.payload_out   = sel_entry.payload;
                    res_next.found_id      = sel_entry.id;
                    res_next.found_channel = sel_entry.ch;
                end
            end
            ltrob_pkg::FN_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
        res_next.occupancy = ltrob_pkg::OCC_W'(fill_next);
        res_next.is_empty  = (fill_next == '0);
        res_next.is_full   = (fill_next >= lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= ltrob_pkg::CAP_RESET;
            fill_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    `LTROB_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= ltrob_pkg::CNT_W'(ltrob_pkg::DEPTH))
    `LTROB_ASSERT_NEXT(a_done_follows, accept, done_reg)
    `LTROB_ASSERT_SAME(a_occ_tracks, done_reg, res_reg.occupancy == ltrob_pkg::OCC_W'(fill_reg))
    `LTROB_ASSERT_NEXT(a_push_grows, push_ok, fill_reg == $past(fill_reg) + 1'b1)
    `LTROB_ASSERT_SAME(a_fail_zero, done_reg && (res_reg.status != ltrob_pkg::ST_OK), res_reg.payload_out == '0)

endmodule
